// ----- rtl/rtpe_pkg.sv -----
// Shared types, constants and helpers for the RGBA to PostScript hex encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtpe_pkg;

	localparam int unsigned PIX_PER_LINE     = 13;
	localparam int unsigned MASK_DIG_PER_LINE = 78;
	localparam logic [7:0]  MASK_ALPHA_LIMIT  = 8'd32;
	localparam logic [7:0]  NEWLINE_CHAR      = 8'd10;

	// Register indexes of the configuration port
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_EMIT_MASK   = 1'b1;

	typedef struct packed {
		logic [15:0] image_width;
		logic        emit_mask;
	} cfg_t;

	// One pixel's worth of work for the text serializer
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       img_nl;
		logic       mask_dig;
		logic [3:0] mask_val;
		logic       mask_pad;
		logic       mask_nl;
	} job_t;

	typedef enum logic [3:0] {
		ST_R_HI,
		ST_R_LO,
		ST_G_HI,
		ST_G_LO,
		ST_B_HI,
		ST_B_LO,
		ST_IMG_NL,
		ST_MASK_DIG,
		ST_MASK_PAD,
		ST_MASK_NL
	} step_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h37 + {4'd0, nib};
		end
		return c;
	endfunction

	// floor(x / 255) for x up to 65025 (255 * 255)
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rtpe_front.sv -----
// Front end: accepts pixels, tracks row/line/mask counters, composites over white.
// Depends on rtpe_pkg.
`default_nettype none

module rtpe_front
	import rtpe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,
	output logic             job_valid,
	input  wire logic        job_ready,
	output job_t             job
);

	logic [15:0] column_q;
	logic [3:0]  pixels_q;
	logic [3:0]  nibble_q;
	logic [6:0]  digits_q;

	logic        valid_s1, valid_s2;
	job_t        job_s1, job_s2;
	logic [7:0]  alpha_s1;
	logic [15:0] sum_r_s2, sum_g_s2, sum_b_s2;

	logic        s2_can, s1_can, accept;
	logic        row_end;
	logic [1:0]  pos;
	logic [15:0] last_col;
	logic [3:0]  nib_new;
	logic [6:0]  dig1, dig2;
	job_t        cls;
	logic [15:0] column_d;
	logic [3:0]  pixels_d, nibble_d;
	logic [6:0]  digits_d;
	logic [15:0] white_part;

	assign s2_can   = !valid_s2 || job_ready;
	assign s1_can   = !valid_s1 || s2_can;
	assign s_tready = s1_can;
	assign accept   = s_tvalid && s1_can;

	// classify the incoming pixel against the running counters
	always_comb begin
		last_col = cfg.image_width - 16'd1;
		row_end  = column_q >= last_col;
		pos      = column_q[1:0];
		cls      = '0;
		cls.red   = s_tdata[7:0];
		cls.green = s_tdata[15:8];
		cls.blue  = s_tdata[23:16];
		cls.img_nl = (pixels_q == 4'(PIX_PER_LINE - 1));
		pixels_d   = cls.img_nl ? 4'd0 : pixels_q + 4'd1;
		nib_new    = nibble_q;
		if (s_tdata[31:24] <= MASK_ALPHA_LIMIT) begin
			nib_new = nibble_q | (4'b1000 >> pos);
		end
		dig1     = digits_q + 7'd1;
		dig2     = dig1;
		nibble_d = 4'd0;
		digits_d = digits_q;
		if (cfg.emit_mask) begin
			if (pos == 2'd3 || row_end) begin
				cls.mask_dig = 1'b1;
				cls.mask_val = nib_new;
				cls.mask_pad = row_end && dig1[0];
				dig2         = dig1 + {6'd0, cls.mask_pad};
				cls.mask_nl  = dig2 >= 7'(MASK_DIG_PER_LINE);
				digits_d     = cls.mask_nl ? 7'd0 : dig2;
			end else begin
				nibble_d = nib_new;
			end
		end
		column_d = row_end ? 16'd0 : column_q + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			pixels_q <= '0;
			nibble_q <= '0;
			digits_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				column_q <= column_d;
				pixels_q <= pixels_d;
				nibble_q <= nibble_d;
				digits_q <= digits_d;
			end
			if (s1_can) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_can) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign white_part = 16'd255 * {8'd0, 8'd255 - alpha_s1};

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1   <= cls;
			alpha_s1 <= s_tdata[31:24];
		end
		if (valid_s1 && s2_can) begin
			job_s2   <= job_s1;
			sum_r_s2 <= {8'd0, job_s1.red}   * {8'd0, alpha_s1} + white_part;
			sum_g_s2 <= {8'd0, job_s1.green} * {8'd0, alpha_s1} + white_part;
			sum_b_s2 <= {8'd0, job_s1.blue}  * {8'd0, alpha_s1} + white_part;
		end
	end

	// divide the blended sums on the way into the queue
	always_comb begin
		job       = job_s2;
		job.red   = div255(sum_r_s2);
		job.green = div255(sum_g_s2);
		job.blue  = div255(sum_b_s2);
	end

	assign job_valid = valid_s2;

endmodule

`default_nettype wire

// ----- rtl/rtpe_queue.sv -----
// Small job queue between the pixel front end and the text serializer.
// Depends on rtpe_pkg.
`default_nettype none

module rtpe_queue
	import rtpe_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      push_ready,
	input  wire job_t push_job,
	output logic      head_valid,
	input  wire logic pop,
	output job_t      head_job
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rtpe_back.sv -----
// Back end: queue head to output register, one character per unstalled cycle.
// Depends on rtpe_pkg.
`default_nettype none

module rtpe_back
	import rtpe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire job_t head_job,
	output logic      pop,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast
);

	step_t      step_q, step_d;
	logic       out_ld, adv, is_last;
	logic [7:0] ch;
	logic       tag;

	assign out_ld = !m_tvalid || m_tready;
	assign adv    = head_valid && out_ld;
	assign pop    = adv && is_last;

	// next step: skip characters this pixel does not produce
	always_comb begin
		step_d  = ST_R_HI;
		is_last = 1'b0;
		unique case (step_q)
			ST_R_HI: step_d = ST_R_LO;
			ST_R_LO: step_d = ST_G_HI;
			ST_G_HI: step_d = ST_G_LO;
			ST_G_LO: step_d = ST_B_HI;
			ST_B_HI: step_d = ST_B_LO;
			ST_B_LO: begin
				if (head_job.img_nl) begin
					step_d = ST_IMG_NL;
				end else if (head_job.mask_dig) begin
					step_d = ST_MASK_DIG;
				end else begin
					is_last = 1'b1;
				end
			end
			ST_IMG_NL: begin
				if (head_job.mask_dig) begin
					step_d = ST_MASK_DIG;
				end else begin
					is_last = 1'b1;
				end
			end
			ST_MASK_DIG: begin
				if (head_job.mask_pad) begin
					step_d = ST_MASK_PAD;
				end else if (head_job.mask_nl) begin
					step_d = ST_MASK_NL;
				end else begin
					is_last = 1'b1;
				end
			end
			ST_MASK_PAD: begin
				if (head_job.mask_nl) begin
					step_d = ST_MASK_NL;
				end else begin
					is_last = 1'b1;
				end
			end
			ST_MASK_NL: is_last = 1'b1;
			default: is_last = 1'b1;
		endcase
	end

	// character and tag for the current step
	always_comb begin
		ch  = NEWLINE_CHAR;
		tag = 1'b0;
		unique case (step_q)
			ST_R_HI:     ch = hex_char(head_job.red[7:4]);
			ST_R_LO:     ch = hex_char(head_job.red[3:0]);
			ST_G_HI:     ch = hex_char(head_job.green[7:4]);
			ST_G_LO:     ch = hex_char(head_job.green[3:0]);
			ST_B_HI:     ch = hex_char(head_job.blue[7:4]);
			ST_B_LO:     ch = hex_char(head_job.blue[3:0]);
			ST_IMG_NL:   ch = NEWLINE_CHAR;
			ST_MASK_DIG: begin
				ch  = hex_char(head_job.mask_val);
				tag = 1'b1;
			end
			ST_MASK_PAD: begin
				ch  = hex_char(4'd0);
				tag = 1'b1;
			end
			ST_MASK_NL: begin
				ch  = NEWLINE_CHAR;
				tag = 1'b1;
			end
			default: ch = NEWLINE_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_R_HI;
			m_tvalid <= 1'b0;
		end else begin
			if (adv) begin
				step_q <= step_d;
			end
			if (out_ld) begin
				m_tvalid <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= ch;
			m_tuser <= tag;
			m_tlast <= is_last;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rgba_to_ps_hex_image_encoder.sv -----
// Top level of the RGBA to PostScript ASCII-hex encoder: config registers and wiring.
// Depends on rtpe_pkg, rtpe_front, rtpe_queue and rtpe_back.
`default_nettype none

// Turns a raster-order stream of RGBA pixels into PostScript ASCII-hex text. Each
// pixel is blended over white per channel and sent as six uppercase hex characters
// (red, green, blue), followed by a newline after every 13th pixel. With emit_mask
// set, a 1-bit mask (alpha <= 32) is packed four pixels to a digit; a digit goes
// out on every fourth column and at row end, a row is padded with '0' to an even
// digit count, and a newline follows every 78 mask digits. Mask characters carry
// tuser = 1, image characters tuser = 0; tlast marks the last character of a pixel.
// Throughput: one output word per unstalled cycle; a pixel makes 6 to 10 characters
// (6 + image newline + mask digit + pad + mask newline); the back-end serializer sets
// that rate. An accepted pixel passes the front end's classify and blend registers
// before it enters the job queue, and its first character is offered from the back
// end's output register; the queue takes new pixels while text still drains.
// Write image_width (index 0) and emit_mask (index 1) only while idle.
module rgba_to_ps_hex_image_encoder
	import rtpe_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	// pixel input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // red, green, blue, alpha (from bit 0 up)
	// text output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // text_char
	output logic             m_tuser,   // stream_tag
	output logic             m_tlast    // last_of_run
);

	logic [15:0] image_width_q;
	logic        emit_mask_q;
	cfg_t        cfg;

	logic        job_valid, job_ready;
	job_t        job;
	logic        q_valid, q_pop;
	job_t        q_job;

	// hold the config; user writes only while the block is idle, not enforced by the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= 16'd1;
			emit_mask_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH: image_width_q <= cfg_wdata;
				REG_EMIT_MASK:   emit_mask_q   <= cfg_wdata[0];
				default:         emit_mask_q   <= emit_mask_q;
			endcase
		end
	end

	assign cfg.image_width = image_width_q;
	assign cfg.emit_mask   = emit_mask_q;

	// front: accept, classify and blend each pixel
	rtpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	// queue: decouple pixel intake from text output
	rtpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_ready (job_ready),
		.push_job   (job),
		.head_valid (q_valid),
		.pop        (q_pop),
		.head_job   (q_job)
	);

	// back: serialize one character per cycle while not stalled
	rtpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_job   (q_job),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

`ifndef SYNTH
	// a mask character only exists while the mask stream is enabled
	a_mask_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> emit_mask_q)
		else $error("mask character emitted with mask disabled");

	// the serializer pops only a job that is present
	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// an image newline closes the pixel unless mask text may follow
	a_img_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && (m_tdata == NEWLINE_CHAR) |-> m_tlast || emit_mask_q)
		else $error("image newline not last without mask");
`endif

endmodule

`default_nettype wire
